FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

FILE: rtl/afcd_pkg.sv
`timescale 1ns / 1ps

package afcd_pkg;

  localparam int unsigned HeadDepth = 6;

  localparam logic [7:0] MaxFrameBytes = 8'd255;
  localparam logic [7:0] SumTarget     = 8'hFF;
  localparam logic [7:0] AtOverhead    = 8'd6;
  localparam logic [7:0] RxOverhead    = 8'd13;
  localparam logic [3:0] AtOffset      = 4'd5;
  localparam logic [3:0] RxOffset      = 4'd12;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] RegAtResponse     = 2'd0;
  localparam logic [1:0] RegModemStatus    = 2'd1;
  localparam logic [1:0] RegTransmitStatus = 2'd2;
  localparam logic [1:0] RegReceivePacket  = 2'd3;

  localparam logic [7:0] RstAtResponse     = 8'd136;
  localparam logic [7:0] RstModemStatus    = 8'd138;
  localparam logic [7:0] RstTransmitStatus = 8'd139;
  localparam logic [7:0] RstReceivePacket  = 8'd144;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_AT_RESP  = 3'd1,
    KIND_MODEM_ST = 3'd2,
    KIND_TX_ST    = 3'd3,
    KIND_RX_PKT   = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0] at_response;
    logic [7:0] modem_status;
    logic [7:0] transmit_status;
    logic [7:0] receive_packet;
  } codes_t;

  // Frame state as seen once the last word is folded in
  typedef struct packed {
    logic [7:0]                count;
    logic [7:0]                sum;
    logic                      overlong;
    logic [HeadDepth-1:0][7:0] head;
  } frame_t;

  typedef struct packed {
    logic       frame_good;
    kind_e      kind;
    logic [7:0] frame_type;
    logic [7:0] frame_id;
    logic [7:0] at_first;
    logic [7:0] at_second;
    logic [7:0] status_byte;
    logic       has_payload;
    logic [3:0] payload_offset;
    logic [7:0] payload_size;
  } result_t;

endpackage

FILE: rtl/afcd_decode.sv
`timescale 1ns / 1ps

module afcd_decode (
  input  afcd_pkg::frame_t  frame_i,
  input  afcd_pkg::codes_t  codes_i,
  output afcd_pkg::result_t result_o
);
  import afcd_pkg::*;

  logic [7:0] type_byte;
  logic       sum_ok;
  kind_e      kind;

  assign type_byte = frame_i.head[0];
  assign sum_ok    = (frame_i.sum == SumTarget) && !frame_i.overlong;

  // First matching code wins
  always_comb begin
    if (!sum_ok) begin
      kind = KIND_NONE;
    end else if (type_byte == codes_i.at_response) begin
      kind = KIND_AT_RESP;
    end else if (type_byte == codes_i.modem_status) begin
      kind = KIND_MODEM_ST;
    end else if (type_byte == codes_i.transmit_status) begin
      kind = KIND_TX_ST;
    end else if (type_byte == codes_i.receive_packet) begin
      kind = KIND_RX_PKT;
    end else begin
      kind = KIND_NONE;
    end
  end

  always_comb begin
    result_o = '0;
    result_o.kind = kind;
    case (kind)
      KIND_AT_RESP: begin
        result_o.frame_good  = 1'b1;
        result_o.frame_type  = type_byte;
        result_o.frame_id    = frame_i.head[1];
        result_o.at_first    = frame_i.head[2];
        result_o.at_second   = frame_i.head[3];
        result_o.status_byte = frame_i.head[4];
        if (frame_i.count > AtOverhead) begin
          result_o.has_payload    = 1'b1;
          result_o.payload_offset = AtOffset;
          result_o.payload_size   = frame_i.count - AtOverhead;
        end
      end
      KIND_MODEM_ST: begin
        result_o.frame_good  = 1'b1;
        result_o.frame_type  = type_byte;
        result_o.status_byte = frame_i.head[1];
      end
      KIND_TX_ST: begin
        result_o.frame_good  = 1'b1;
        result_o.frame_type  = type_byte;
        result_o.frame_id    = frame_i.head[1];
        result_o.status_byte = frame_i.head[5];
      end
      KIND_RX_PKT: begin
        result_o.frame_good = 1'b1;
        result_o.frame_type = type_byte;
        if (frame_i.count > RxOverhead) begin
          result_o.has_payload    = 1'b1;
          result_o.payload_offset = RxOffset;
          result_o.payload_size   = frame_i.count - RxOverhead;
        end
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

endmodule

FILE: rtl/api_frame_checksum_decoder_core.sv
`timescale 1ns / 1ps
// API frame checksum decoder.
// Input channel (in_valid_i / in_ready_o): one frame byte per word, type byte
// first, checksum byte last with is_last_i set. Output channel (out_valid_o /
// out_ready_i): one result word per frame, carrying the decoded header fields.
// APB port: four 8-bit type-code registers at byte addresses 0, 4, 8, 12.
// Throughput: one byte per cycle while in_ready_o is high, set by the
// combined count/sum/capture update; frames may follow each other with no gap.
// Latency: the result word shows on out_valid_o the cycle after the last byte
// is taken; decode runs between the frame registers and the result register.
// Stall: the result register holds until taken. Non-last bytes keep flowing
// while a result waits; a last byte is held off (in_ready_o low) only while
// the previous result is still untaken.
// Reset: frame count, sum, head bytes and overlong flag clear, the code
// registers return to their defaults, and no result is pending.
`include "assert_macros.svh"

module api_frame_checksum_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        is_last_i,
  // result out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_good_o,
  output logic [2:0]  kind_o,
  output logic [7:0]  frame_type_o,
  output logic [7:0]  frame_id_o,
  output logic [7:0]  at_first_o,
  output logic [7:0]  at_second_o,
  output logic [7:0]  status_byte_o,
  output logic        has_payload_o,
  output logic [3:0]  payload_offset_o,
  output logic [7:0]  payload_size_o
);
  import afcd_pkg::*;

  // ---------------- configuration registers ----------------
  codes_t     codes_q;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.at_response     <= RstAtResponse;
      codes_q.modem_status    <= RstModemStatus;
      codes_q.transmit_status <= RstTransmitStatus;
      codes_q.receive_packet  <= RstReceivePacket;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegAtResponse:     codes_q.at_response     <= pwdata[7:0];
        RegModemStatus:    codes_q.modem_status    <= pwdata[7:0];
        RegTransmitStatus: codes_q.transmit_status <= pwdata[7:0];
        RegReceivePacket:  codes_q.receive_packet  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegAtResponse:     prdata = {24'd0, codes_q.at_response};
      RegModemStatus:    prdata = {24'd0, codes_q.modem_status};
      RegTransmitStatus: prdata = {24'd0, codes_q.transmit_status};
      RegReceivePacket:  prdata = {24'd0, codes_q.receive_packet};
      default:           prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  logic out_valid_q;
  logic out_free;
  logic in_acc;
  logic last_acc;

  assign out_free   = !out_valid_q || out_ready_i;
  // Only the last byte needs a free result slot
  assign in_ready_o = out_free || !is_last_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign last_acc   = in_acc && is_last_i;

  // ---------------- frame accumulation ----------------
  frame_t frame_q;
  frame_t frame_d;

  always_comb begin
    frame_d     = frame_q;
    frame_d.sum = frame_q.sum + data_byte_i;
    if (frame_q.count >= MaxFrameBytes) begin
      frame_d.overlong = 1'b1;   // count saturates, sum keeps running
    end else begin
      for (int i = 0; i < HeadDepth; i++) begin
        if (frame_q.count == 8'(i)) begin
          frame_d.head[i] = data_byte_i;
        end
      end
      frame_d.count = frame_q.count + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else if (in_acc) begin
      if (is_last_i) begin
        frame_q <= '0;           // next frame starts clean
      end else begin
        frame_q <= frame_d;
      end
    end
  end

  // ---------------- decode and result register ----------------
  result_t result_d;
  result_t result_q;

  afcd_decode u_decode (
    .frame_i  (frame_d),
    .codes_i  (codes_q),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (last_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_acc) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_good_o     = result_q.frame_good;
  assign kind_o           = result_q.kind;
  assign frame_type_o     = result_q.frame_type;
  assign frame_id_o       = result_q.frame_id;
  assign at_first_o       = result_q.at_first;
  assign at_second_o      = result_q.at_second;
  assign status_byte_o    = result_q.status_byte;
  assign has_payload_o    = result_q.has_payload;
  assign payload_offset_o = result_q.payload_offset;
  assign payload_size_o   = result_q.payload_size;

  // ---------------- assertions ----------------
  `ASSERT_CLK(a_last_gives_word, clk_i, rst_ni, last_acc |=> out_valid_o, "last byte gave no result")
  `ASSERT_CLK(a_no_spurious_word, clk_i, rst_ni, (!out_valid_o && !last_acc) |=> !out_valid_o, "result without last byte")
  `ASSERT_CLK(a_good_vs_kind, clk_i, rst_ni, out_valid_o |-> (frame_good_o == (kind_o != KIND_NONE)), "good flag and kind disagree")
  `ASSERT_NEVER(a_payload_flag, clk_i, rst_ni, out_valid_o && (has_payload_o != (payload_size_o != 8'd0)), "payload flag and size disagree")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import afcd_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned IdlePct     = 29;
  // settle time added once the owed results have drained
  localparam int unsigned DrainCycles = 4;

  // Frame decode predictor plus the queue of results still owed by the block.
  class frame_scoreboard;
    logic [7:0] codes [4];
    logic [7:0] byte_count;
    logic [7:0] running_sum;
    logic [7:0] head [HeadDepth];
    logic       overlong;
    result_t    owed_q [$];
    int unsigned mismatches;

    function new();
      codes[RegAtResponse]     = RstAtResponse;
      codes[RegModemStatus]    = RstModemStatus;
      codes[RegTransmitStatus] = RstTransmitStatus;
      codes[RegReceivePacket]  = RstReceivePacket;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_count  = '0;
      running_sum = '0;
      overlong    = 1'b0;
      foreach (head[i]) head[i] = '0;
    endfunction

    function void set_code(logic [1:0] idx, logic [7:0] value);
      codes[idx] = value;
    endfunction

    function result_t decode_frame();
      result_t    r;
      logic [7:0] t;
      r = '0;
      t = head[0];
      if (running_sum == SumTarget && !overlong) begin
        // first matching register wins when codes are equal
        if (t == codes[RegAtResponse]) r.kind = KIND_AT_RESP;
        else if (t == codes[RegModemStatus]) r.kind = KIND_MODEM_ST;
        else if (t == codes[RegTransmitStatus]) r.kind = KIND_TX_ST;
        else if (t == codes[RegReceivePacket]) r.kind = KIND_RX_PKT;
        if (r.kind != KIND_NONE) begin
          r.frame_good = 1'b1;
          r.frame_type = t;
          case (r.kind)
            KIND_AT_RESP: begin
              r.frame_id    = head[1];
              r.at_first    = head[2];
              r.at_second   = head[3];
              r.status_byte = head[4];
              if (byte_count > AtOverhead) begin
                r.has_payload    = 1'b1;
                r.payload_offset = AtOffset;
                r.payload_size   = byte_count - AtOverhead;
              end
            end
            KIND_MODEM_ST: r.status_byte = head[1];
            KIND_TX_ST: begin
              r.frame_id    = head[1];
              r.status_byte = head[5];
            end
            default: begin
              if (byte_count > RxOverhead) begin
                r.has_payload    = 1'b1;
                r.payload_offset = RxOffset;
                r.payload_size   = byte_count - RxOverhead;
              end
            end
          endcase
        end
      end
      return r;
    endfunction

    // one accepted input word
    function void note_input(logic [7:0] b, logic is_end);
      if (byte_count >= MaxFrameBytes) begin
        overlong = 1'b1;
      end else begin
        if (byte_count < HeadDepth) head[byte_count] = b;
        byte_count = byte_count + 8'd1;
      end
      running_sum = running_sum + b;
      if (is_end) begin
        owed_q.push_back(decode_frame());
        clear_frame();
      end
    endfunction

    task report(string msg);
      $display("tb_top: mismatch: %s", msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // one accepted result word
    task check_result(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        report("result word with nothing owed");
      end else begin
        want = owed_q.pop_front();
        compare_field("frame_good", 8'(got.frame_good), 8'(want.frame_good));
        compare_field("kind", 8'(got.kind), 8'(want.kind));
        compare_field("frame_type", got.frame_type, want.frame_type);
        compare_field("frame_id", got.frame_id, want.frame_id);
        compare_field("at_first", got.at_first, want.at_first);
        compare_field("at_second", got.at_second, want.at_second);
        compare_field("status_byte", got.status_byte, want.status_byte);
        compare_field("has_payload", 8'(got.has_payload), 8'(want.has_payload));
        compare_field("payload_offset", 8'(got.payload_offset), 8'(want.payload_offset));
        compare_field("payload_size", got.payload_size, want.payload_size);
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;

  // APB side
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // byte channel
  logic        byte_valid = 1'b0;
  logic        byte_ready;
  logic [7:0]  byte_data = '0;
  logic        byte_last = 1'b0;

  // result channel
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic        frame_good;
  logic [2:0]  kind;
  logic [7:0]  frame_type;
  logic [7:0]  frame_id;
  logic [7:0]  at_first;
  logic [7:0]  at_second;
  logic [7:0]  status_byte;
  logic        has_payload;
  logic [3:0]  payload_offset;
  logic [7:0]  payload_size;
  result_t     seen;

  // steady: no idling on either side while set
  logic        steady = 1'b0;
  int unsigned cycles = 0;
  logic [7:0]  frame_buf [$];

  frame_scoreboard sb;

  api_frame_checksum_decoder_core i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (byte_valid),
    .in_ready_o       (byte_ready),
    .data_byte_i      (byte_data),
    .is_last_i        (byte_last),
    .out_valid_o      (res_valid),
    .out_ready_i      (res_ready),
    .frame_good_o     (frame_good),
    .kind_o           (kind),
    .frame_type_o     (frame_type),
    .frame_id_o       (frame_id),
    .at_first_o       (at_first),
    .at_second_o      (at_second),
    .status_byte_o    (status_byte),
    .has_payload_o    (has_payload),
    .payload_offset_o (payload_offset),
    .payload_size_o   (payload_size)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always_comb begin
    seen.frame_good     = frame_good;
    seen.kind           = kind_e'(kind);
    seen.frame_type     = frame_type;
    seen.frame_id       = frame_id;
    seen.at_first       = at_first;
    seen.at_second      = at_second;
    seen.status_byte    = status_byte;
    seen.has_payload    = has_payload;
    seen.payload_offset = payload_offset;
    seen.payload_size   = payload_size;
  end

  // Result side stalls ~29% of cycles unless in a steady stretch.
  always @(negedge clk) begin
    res_ready <= steady || ($urandom_range(99) >= IdlePct);
  end

  // Sampled at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n && res_valid && res_ready) sb.check_result(seen);
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Send one word; random idle cycles go in front of it.
  task automatic send_word(input logic [7:0] b, input logic is_end);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IdlePct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= b;
    byte_last  <= is_end;
    do @(posedge clk); while (!byte_ready);
    sb.note_input(b, is_end);
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_word(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // Append the checksum byte that brings the frame sum to 0xFF.
  function automatic void seal_frame();
    logic [7:0] s;
    s = '0;
    foreach (frame_buf[i]) s = s + frame_buf[i];
    frame_buf.push_back(SumTarget - s);
  endfunction

  // Random body; a one-byte frame is its own checksum.
  function automatic void build_frame(logic [7:0] ftype, int unsigned len, bit good_sum);
    frame_buf.delete();
    frame_buf.push_back(ftype);
    if (len > 1) begin
      for (int unsigned i = 2; i < len; i++) frame_buf.push_back(8'($urandom_range(255)));
      if (good_sum) seal_frame();
      else frame_buf.push_back(8'($urandom_range(255)));
    end
  endfunction

  // Hold the sender off until every owed result is in, plus some settle time.
  task automatic drain(input int unsigned settle);
    @(negedge clk);
    byte_valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_code(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Only called with the block idle.
  task automatic set_codes(input logic [7:0] at_code, input logic [7:0] ms_code,
                           input logic [7:0] tx_code, input logic [7:0] rx_code);
    drain(DrainCycles);
    apb_write(RegAtResponse, at_code);
    apb_write(RegModemStatus, ms_code);
    apb_write(RegTransmitStatus, tx_code);
    apb_write(RegReceivePacket, rx_code);
  endtask

  // Mostly well-formed short frames of known types; some junk types and
  // broken checksums. Occasionally the sender waits for the results to drain.
  task automatic run_random(input int unsigned quota);
    int unsigned sent;
    int unsigned len;
    logic [7:0]  ftype;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(99) < 80) ftype = sb.codes[$urandom_range(3)];
      else ftype = 8'($urandom_range(255));
      if ($urandom_range(9) == 0) len = $urandom_range(40, 21);
      else len = $urandom_range(20, 1);
      build_frame(ftype, len, $urandom_range(99) < 85);
      send_frame();
      sent += len;
      if ($urandom_range(15) == 0) drain(0);
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames under reset codes.
    // Lone 0xFF byte: checksum fine, type unknown.
    frame_buf = '{8'hFF};
    send_frame();
    // AT response with one payload byte, extreme byte values in the header.
    frame_buf = '{RstAtResponse, 8'h00, 8'h41, 8'h54, 8'hFF, 8'h7E};
    seal_frame();
    send_frame();
    frame_buf = '{RstModemStatus, 8'h02};
    seal_frame();
    send_frame();
    // Transmit status too short to carry its status byte.
    frame_buf = '{RstTransmitStatus, 8'hFF, 8'h00};
    seal_frame();
    send_frame();
    // Receive packet with nothing after the header.
    frame_buf = '{RstReceivePacket, 8'h80};
    seal_frame();
    send_frame();
    // Bad checksum.
    frame_buf = '{RstAtResponse, 8'h01, 8'h02, 8'h00};
    send_frame();

    run_random(210);

    // Extreme codes, with a no-idle stretch on both sides.
    set_codes(8'h00, 8'hFF, 8'h01, 8'h80);
    steady <= 1'b1;
    run_random(210);
    steady <= 1'b0;
    // Longest legal frame: largest AT payload.
    build_frame(8'h00, 255, 1'b1);
    send_frame();
    // One byte past the limit: bad despite a correct checksum.
    build_frame(8'hFF, 256, 1'b1);
    send_frame();

    // All codes equal: AT response must win.
    set_codes(8'h55, 8'h55, 8'h55, 8'h55);
    run_random(210);

    set_codes(8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 8'($urandom_range(255)));
    run_random(220);

    drain(DrainCycles);
    if (sb.mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
